FILE: sv/cte_pkg.sv
// Package: types, constants and the month-length table for the calendar time-set editor.
package cte_pkg;

    localparam int YEAR_W   = 7;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MIN_W    = 6;
    localparam int SEC_W    = 6;
    localparam int SEL_W    = 3;
    localparam int PERIOD_W = 10;
    localparam int IN_DW    = 40;
    localparam int OUT_DW   = 40;

    localparam logic [PERIOD_W-1:0] BLINK_RESET = 10'd500;
    localparam logic [YEAR_W-1:0]   YEAR_MAX    = 7'd99;
    localparam logic [MONTH_W-1:0]  MONTH_MAX   = 4'd12;
    localparam logic [HOUR_W-1:0]   HOUR_MAX    = 5'd23;
    localparam logic [MIN_W-1:0]    MIN_MAX     = 6'd59;
    localparam logic [SEC_W-1:0]    SEC_MAX     = 6'd59;
    localparam logic [SEL_W-1:0]    SEL_LAST    = 3'd5;

    typedef enum logic [2:0] {
        OP_TICK = 3'd0,
        OP_MODE = 3'd1,
        OP_SEL  = 3'd2,
        OP_INC  = 3'd3,
        OP_DEC  = 3'd4,
        OP_LOAD = 3'd5
    } t_op;

    typedef enum logic [SEL_W-1:0] {
        FLD_YEAR   = 3'd0,
        FLD_MONTH  = 3'd1,
        FLD_DAY    = 3'd2,
        FLD_HOUR   = 3'd3,
        FLD_MINUTE = 3'd4,
        FLD_SECOND = 3'd5
    } t_field;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [HOUR_W-1:0]  hour;
        logic [MIN_W-1:0]   minute;
        logic [SEC_W-1:0]   second;
    } t_time;

    typedef struct packed {
        logic             set_mode;
        logic [SEL_W-1:0] field_sel;
        logic             blank_field;
        t_time            tm;
        logic             write_back;
    } t_res;

    // Days in a month; an out-of-range month reads as January. Leap when year % 4 == 0.
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                   input logic [YEAR_W-1:0] year);
        logic [DAY_W-1:0] len;
        unique case (month)
            4'd2:                    len = (year[1:0] == 2'd0) ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            default:                 len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

FILE: sv/calendar_time_set_editor.sv
// Top level: input beat register, editor core and output result register.
// An accepted beat passes two register stages: input register, then result register.
// Throughput: one beat per cycle; the input register refills while a result waits.
// A stalled output holds the input register, which then backs up the input side.
// Reset (synchronous, active low): show mode, field 0, blink off, time 00-01-01 00:00:00,
// blink period 500, both registers empty.
module calendar_time_set_editor (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [cte_pkg::PERIOD_W-1:0]  i_cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [6:0] load_year, [10:7] load_month, [15:11] load_day, [20:16] load_hour,
    // [26:21] load_minute, [32:27] load_second, [39:33] zero
    input  logic [cte_pkg::IN_DW-1:0]     s_tdata,
    // [2:0] op
    input  logic [2:0]                    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [0] set_mode, [3:1] field_sel, [4] blank_field, [11:5] year_out, [15:12] month_out,
    // [20:16] day_out, [25:21] hour_out, [31:26] minute_out, [37:32] second_out,
    // [38] write_back, [39] zero
    output logic [cte_pkg::OUT_DW-1:0]    m_tdata
);
    import cte_pkg::*;

    logic   r_in_valid;
    t_op    r_in_op;
    t_time  r_in_load;
    logic   r_out_valid;
    t_res   r_out;
    t_res   w_res;
    logic   w_adv;

    assign w_adv    = r_in_valid && (!r_out_valid || m_tready);
    assign s_tready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_tready) begin
            r_in_valid <= s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_tready && s_tvalid) begin
            r_in_op   <= t_op'(s_tuser);
            r_in_load <= '{year: s_tdata[6:0], month: s_tdata[10:7], day: s_tdata[15:11],
                           hour: s_tdata[20:16], minute: s_tdata[26:21],
                           second: s_tdata[32:27]};
        end
    end

    cte_edit u_edit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_en        (w_adv),
        .i_op        (r_in_op),
        .i_load      (r_in_load),
        .o_res       (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || m_tready) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= w_res;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {1'b0, r_out.write_back, r_out.tm.second, r_out.tm.minute,
                       r_out.tm.hour, r_out.tm.day, r_out.tm.month, r_out.tm.year,
                       r_out.blank_field, r_out.field_sel, r_out.set_mode};

endmodule

FILE: sv/cte_edit.sv
// Editor state registers and the combinational update for one beat.
module cte_edit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [cte_pkg::PERIOD_W-1:0]  i_cfg_wdata,
    input  logic                          i_en,
    input  cte_pkg::t_op                  i_op,
    input  cte_pkg::t_time                i_load,
    output cte_pkg::t_res                 o_res
);
    import cte_pkg::*;

    logic [PERIOD_W-1:0] r_period;
    logic [PERIOD_W-1:0] r_tick, n_tick;
    logic                r_mode, n_mode;
    logic [SEL_W-1:0]    r_sel, n_sel;
    logic                r_blink, n_blink;
    t_time               r_tm, n_tm;
    logic                n_wb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= BLINK_RESET;
        end else if (i_cfg_we) begin
            r_period <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick   <= '0;
            r_mode   <= 1'b0;
            r_sel    <= '0;
            r_blink  <= 1'b0;
            r_tm     <= '{year: '0, month: 4'd1, day: 5'd1, hour: '0, minute: '0, second: '0};
        end else if (i_en) begin
            r_tick   <= n_tick;
            r_mode   <= n_mode;
            r_sel    <= n_sel;
            r_blink  <= n_blink;
            r_tm     <= n_tm;
        end
    end

    always_comb begin
        logic [PERIOD_W-1:0] cnt;
        logic [YEAR_W:0]     y;
        logic [MONTH_W:0]    m;
        logic [DAY_W:0]      d;
        logic [HOUR_W:0]     h;
        logic [MIN_W:0]      mi;
        logic [SEC_W:0]      s;
        logic [DAY_W-1:0]    len;

        n_tick  = r_tick;
        n_mode  = r_mode;
        n_sel   = r_sel;
        n_blink = r_blink;
        n_tm    = r_tm;
        n_wb    = 1'b0;
        cnt     = r_tick + PERIOD_W'(1);
        y       = {1'b0, r_tm.year};
        m       = {1'b0, r_tm.month};
        d       = {1'b0, r_tm.day};
        h       = {1'b0, r_tm.hour};
        mi      = {1'b0, r_tm.minute};
        s       = {1'b0, r_tm.second};
        len     = '0;

        unique case (i_op)
            OP_TICK: begin
                if (cnt >= r_period || r_period == '0) begin
                    n_tick  = '0;
                    n_blink = ~r_blink;
                end else begin
                    n_tick  = cnt;
                end
            end
            OP_MODE: begin
                if (!r_mode) begin
                    n_mode = 1'b1;
                end else begin
                    n_mode = 1'b0;
                    n_sel  = '0;
                    n_wb   = 1'b1;
                end
            end
            OP_SEL: begin
                if (r_mode) begin
                    n_sel = (r_sel >= SEL_LAST) ? '0 : r_sel + SEL_W'(1);
                end
            end
            OP_INC: begin
                if (r_mode) begin
                    unique case (r_sel)
                        FLD_YEAR:   y  = y + 1'b1;
                        FLD_MONTH:  m  = m + 1'b1;
                        FLD_DAY:    d  = d + 1'b1;
                        FLD_HOUR:   h  = h + 1'b1;
                        FLD_MINUTE: mi = mi + 1'b1;
                        default:    s  = s + 1'b1;
                    endcase
                    if (y > {1'b0, YEAR_MAX}) y = '0;
                    if (m > {1'b0, MONTH_MAX}) m = (MONTH_W+1)'(1);
                    len = month_len(m[MONTH_W-1:0], y[YEAR_W-1:0]);
                    if (d > {1'b0, len}) d = (DAY_W+1)'(1);
                    if (h > {1'b0, HOUR_MAX}) h = '0;
                    if (mi > {1'b0, MIN_MAX}) mi = '0;
                    if (s > {1'b0, SEC_MAX}) s = '0;
                    n_tm = '{year: y[YEAR_W-1:0], month: m[MONTH_W-1:0],
                             day: d[DAY_W-1:0], hour: h[HOUR_W-1:0],
                             minute: mi[MIN_W-1:0], second: s[SEC_W-1:0]};
                end
            end
            OP_DEC: begin
                if (r_mode) begin
                    unique case (r_sel)
                        FLD_YEAR:   y  = (y == '0) ? {1'b0, YEAR_MAX} : y - 1'b1;
                        FLD_MONTH:  m  = (m <= (MONTH_W+1)'(1)) ? {1'b0, MONTH_MAX}
                                                                : m - 1'b1;
                        FLD_DAY:    d  = (d == '0) ? '0 : d - 1'b1;
                        FLD_HOUR:   h  = (h == '0) ? {1'b0, HOUR_MAX} : h - 1'b1;
                        FLD_MINUTE: mi = (mi == '0) ? {1'b0, MIN_MAX} : mi - 1'b1;
                        default:    s  = (s == '0) ? {1'b0, SEC_MAX} : s - 1'b1;
                    endcase
                    len = month_len(m[MONTH_W-1:0], y[YEAR_W-1:0]);
                    if (d == '0 || d > {1'b0, len}) d = {1'b0, len};
                    n_tm = '{year: y[YEAR_W-1:0], month: m[MONTH_W-1:0],
                             day: d[DAY_W-1:0], hour: h[HOUR_W-1:0],
                             minute: mi[MIN_W-1:0], second: s[SEC_W-1:0]};
                end
            end
            OP_LOAD: begin
                if (!r_mode) begin
                    n_tm.year   = (i_load.year > YEAR_MAX) ? YEAR_MAX : i_load.year;
                    n_tm.month  = (i_load.month == '0) ? MONTH_W'(1) :
                                  ((i_load.month > MONTH_MAX) ? MONTH_MAX : i_load.month);
                    n_tm.day    = (i_load.day == '0) ? DAY_W'(1) : i_load.day;
                    n_tm.hour   = (i_load.hour > HOUR_MAX) ? HOUR_MAX : i_load.hour;
                    n_tm.minute = (i_load.minute > MIN_MAX) ? MIN_MAX : i_load.minute;
                    n_tm.second = (i_load.second > SEC_MAX) ? SEC_MAX : i_load.second;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_res = '{set_mode: n_mode, field_sel: n_sel, blank_field: n_mode & n_blink,
                     tm: n_tm, write_back: n_wb};

endmodule

FILE: dv/tb_calendar_time_set_editor.sv
// Testbench for the calendar time-set editor: directed and random beats against a predictor.
`timescale 1ns / 100ps

import cte_pkg::*;

localparam logic [2:0] OP_BAD6 = 3'd6;
localparam logic [2:0] OP_BAD7 = 3'd7;

typedef struct {
    logic       set_mode;
    logic [2:0] sel;
    logic       blank;
    logic [6:0] year;
    logic [3:0] month;
    logic [4:0] day;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic       wb;
} t_shown;

class time_edit_board;
    bit [9:0] period;
    bit       set_mode;
    bit [2:0] sel;
    bit       blink;
    bit [9:0] ticks;
    int       year, month, day, hour, minute, second;
    t_shown   shown_q[$];
    int       checked, mismatches, wb_seen, blank_seen;

    function new();
        period = BLINK_RESET;
        set_mode = 0; sel = 0; blink = 0; ticks = 0;
        year = 0; month = 1; day = 1; hour = 0; minute = 0; second = 0;
    endfunction

    function void set_period(bit [9:0] p);
        period = p;
    endfunction

    function int pending();
        return shown_q.size();
    endfunction

    function int month_days(int m, int y);
        if (m < 1 || m > 12) m = 1;
        if (m == 2) return (y % 4 == 0) ? 29 : 28;
        case (m)
            4, 6, 9, 11: return 30;
            default: return 31;
        endcase
    endfunction

    function void note_key(logic [2:0] op, logic [39:0] data);
        t_shown e;
        bit     wb;
        int     len, m, d;
        wb = 0;
        case (op)
            OP_TICK: begin
                ticks = ticks + 10'd1;
                if (ticks >= period || period == 0) begin
                    ticks = 0;
                    blink = ~blink;
                end
            end
            OP_MODE: begin
                if (!set_mode) begin
                    set_mode = 1;
                end else begin
                    set_mode = 0;
                    sel = 0;
                    wb = 1;
                end
            end
            OP_SEL: if (set_mode) sel = (sel == FLD_SECOND) ? FLD_YEAR : sel + 3'd1;
            OP_INC: if (set_mode) begin
                case (sel)
                    FLD_YEAR: year++;
                    FLD_MONTH: month++;
                    FLD_DAY: day++;
                    FLD_HOUR: hour++;
                    FLD_MINUTE: minute++;
                    default: second++;
                endcase
                if (year > 99) year = 0;
                if (month > 12) month = 1;
                len = month_days(month, year);
                if (day > len) day = 1;
                if (hour > 23) hour = 0;
                if (minute > 59) minute = 0;
                if (second > 59) second = 0;
            end
            OP_DEC: if (set_mode) begin
                case (sel)
                    FLD_YEAR: year = (year == 0) ? 99 : year - 1;
                    FLD_MONTH: month = (month <= 1) ? 12 : month - 1;
                    FLD_DAY: day = (day == 0) ? 0 : day - 1;
                    FLD_HOUR: hour = (hour == 0) ? 23 : hour - 1;
                    FLD_MINUTE: minute = (minute == 0) ? 59 : minute - 1;
                    default: second = (second == 0) ? 59 : second - 1;
                endcase
                len = month_days(month, year);
                if (day < 1) day = len;
                if (day > len) day = len;
            end
            OP_LOAD: if (!set_mode) begin
                m = data[10:7];
                d = data[15:11];
                year = (data[6:0] > 99) ? 99 : data[6:0];
                month = (m == 0) ? 1 : ((m > 12) ? 12 : m);
                day = (d == 0) ? 1 : d;
                hour = (data[20:16] > 23) ? 23 : data[20:16];
                minute = (data[26:21] > 59) ? 59 : data[26:21];
                second = (data[32:27] > 59) ? 59 : data[32:27];
            end
            default: ;
        endcase
        e.set_mode = set_mode;
        e.sel = sel;
        e.blank = set_mode & blink;
        e.year = year[6:0];
        e.month = month[3:0];
        e.day = day[4:0];
        e.hour = hour[4:0];
        e.minute = minute[5:0];
        e.second = second[5:0];
        e.wb = wb;
        shown_q.push_back(e);
    endfunction

    function string show(t_shown v);
        return $sformatf("mode=%0d sel=%0d blank=%0d %0d-%0d-%0d %0d:%0d:%0d wb=%0d",
                         v.set_mode, v.sel, v.blank, v.year, v.month, v.day,
                         v.hour, v.minute, v.second, v.wb);
    endfunction

    function void check_shown(logic [39:0] d);
        t_shown a, e;
        string  bad;
        a.set_mode = d[0];
        a.sel = d[3:1];
        a.blank = d[4];
        a.year = d[11:5];
        a.month = d[15:12];
        a.day = d[20:16];
        a.hour = d[25:21];
        a.minute = d[31:26];
        a.second = d[37:32];
        a.wb = d[38];
        if (shown_q.size() == 0) begin
            if (mismatches < 10) $display("result beat with nothing expected: %s", show(a));
            mismatches++;
            return;
        end
        e = shown_q.pop_front();
        checked++;
        if (a.wb === 1'b1) wb_seen++;
        if (a.blank === 1'b1) blank_seen++;
        bad = "";
        if (a.set_mode !== e.set_mode) bad = {bad, " set_mode"};
        if (a.sel !== e.sel) bad = {bad, " field_sel"};
        if (a.blank !== e.blank) bad = {bad, " blank_field"};
        if (a.year !== e.year) bad = {bad, " year"};
        if (a.month !== e.month) bad = {bad, " month"};
        if (a.day !== e.day) bad = {bad, " day"};
        if (a.hour !== e.hour) bad = {bad, " hour"};
        if (a.minute !== e.minute) bad = {bad, " minute"};
        if (a.second !== e.second) bad = {bad, " second"};
        if (a.wb !== e.wb) bad = {bad, " write_back"};
        if (bad != "") begin
            if (mismatches < 10) begin
                $display("mismatch on result %0d:%s", checked, bad);
                $display("  expected %s", show(e));
                $display("  actual   %s", show(a));
            end
            mismatches++;
        end
    endfunction
endclass

module tb_calendar_time_set_editor;

    localparam int ITEMS_PER_PHASE = 205;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_we = 1'b0;
    logic [PERIOD_W-1:0] i_cfg_wdata = '0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [IN_DW-1:0]    s_tdata = '0;
    logic [2:0]          s_tuser = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [OUT_DW-1:0]   m_tdata;

    logic [8:0]          rx_cycle = '0;
    time_edit_board      board = new();
    int                  beats_sent = 0;
    int                  settings_used = 1;

    calendar_time_set_editor dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always #5 i_clk = ~i_clk;

    // receiver backpressure: the pattern follows bits [8:7] of a free-running cycle counter
    always @(posedge i_clk) begin
        rx_cycle <= rx_cycle + 9'd1;
        case (rx_cycle[8:7])
            2'd0: m_tready <= 1'b1;
            2'd1: m_tready <= 1'($urandom_range(0, 1));
            2'd2: m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= (rx_cycle[3:0] < 4'd11);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) board.check_shown(m_tdata);
    end

    function automatic logic [39:0] pack_load(int y, int m, int d, int h, int mi, int s);
        return {7'd0, s[5:0], mi[5:0], h[4:0], d[4:0], m[3:0], y[6:0]};
    endfunction

    task automatic send_beat(logic [2:0] op, logic [39:0] data);
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= data;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        board.note_key(op, data);
        beats_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_period(logic [9:0] p);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= p;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        board.set_period(p);
        settings_used++;
    endtask

    initial begin
        #5ms;
        $display("timeout with %0d results outstanding", board.pending());
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        int          periods[9];
        int          burst_left, r;
        logic [2:0]  op;
        logic [39:0] data;
        logic [63:0] rnd;

        periods = '{1, 0, 1023, 2, 3, 500, 7, 1023, 1};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: ignored keys, load saturation, wraps of every field but the day in set mode
        send_beat(OP_SEL, '0);
        send_beat(OP_LOAD, {7'd0, 33'h1_FFFF_FFFF});
        send_beat(OP_LOAD, '0);
        send_beat(OP_LOAD, pack_load(99, 2, 29, 23, 59, 59));
        send_beat(OP_MODE, '0);
        send_beat(OP_LOAD, pack_load(10, 5, 5, 5, 5, 5));
        send_beat(OP_INC, '0);
        send_beat(OP_DEC, '0);
        send_beat(OP_SEL, '0);
        send_beat(OP_DEC, '0);
        send_beat(OP_DEC, '0);
        send_beat(OP_INC, '0);
        send_beat(OP_SEL, '0);
        send_beat(OP_INC, '0);
        send_beat(OP_SEL, '0);
        send_beat(OP_INC, '0);
        send_beat(OP_DEC, '0);
        send_beat(OP_SEL, '0);
        send_beat(OP_INC, '0);
        send_beat(OP_SEL, '0);
        send_beat(OP_INC, '0);
        send_beat(OP_DEC, '0);
        send_beat(OP_SEL, '0);
        send_beat(OP_BAD6, '0);
        send_beat(OP_MODE, '0);
        send_beat(OP_TICK, '0);

        foreach (periods[p]) begin
            write_period(PERIOD_W'(periods[p]));
            burst_left = 0;
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 24);
                    r = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    if (r != 0) begin
                        s_tvalid <= 1'b0;
                        repeat (r) @(posedge i_clk);
                    end
                end
                burst_left--;
                rnd = {$urandom, $urandom};
                data = {7'd0, rnd[32:0]};
                r = $urandom_range(0, 99);
                if (r < 30) op = OP_TICK;
                else if (r < 38) op = OP_MODE;
                else if (r < 50) op = OP_SEL;
                else if (r < 70) op = OP_INC;
                else if (r < 88) op = OP_DEC;
                else if (r < 97) op = OP_LOAD;
                else op = rnd[40] ? OP_BAD7 : OP_BAD6;
                if (op == OP_LOAD && $urandom_range(0, 4) != 0)
                    data = pack_load($urandom_range(0, 99), $urandom_range(1, 12),
                                     $urandom_range(1, 31), $urandom_range(0, 23),
                                     $urandom_range(0, 59), $urandom_range(0, 59));
                send_beat(op, data);
            end
        end

        drain();
        repeat (10) @(posedge i_clk);
        $display("Sent %0d key/tick/load beats under %0d blink-period settings,",
                 beats_sent, settings_used);
        $display("%0d results checked, %0d write-backs and %0d blanked; %0d mismatches",
                 board.checked, board.wb_seen, board.blank_seen, board.mismatches);
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
